[hdl/imu_tracker_packet_decoder_top_defines.svh]
// Assertion macros for the IMU tracker packet decoder.
`ifndef IMU_TRACKER_PACKET_DECODER_TOP_DEFINES_SVH
`define IMU_TRACKER_PACKET_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ITPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ITPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ITPD_ASSERT(lbl, clk, rstn, prop, msg)
`define ITPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/itpd_pkg.sv]
// Types, constants and helper functions of the IMU tracker packet decoder.
package itpd_pkg;

    localparam int TRK_W = 6;

    localparam logic [7:0] TYPE_INFO = 8'd0;
    localparam logic [7:0] TYPE_FULL = 8'd1;
    localparam logic [7:0] TYPE_ROT  = 8'd2;
    localparam logic [7:0] TYPE_QUAT = 8'd4;
    localparam logic [7:0] TYPE_REG  = 8'd255;

    localparam logic [1:0] RES_INFO = 2'd0;
    localparam logic [1:0] RES_ROT  = 2'd1;
    localparam logic [1:0] RES_ACC  = 2'd2;
    localparam logic [1:0] RES_BAT  = 2'd3;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [29:0] GAIN_Q30    = 30'd652032874;
    localparam int          SQRT_STEPS  = 16;

    typedef struct packed {
        logic [63:0] packet_low;
        logic [63:0] packet_high;
        logic [6:0]  report_length;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [3:0]         tracker_index;
        logic signed [15:0] comp_x;
        logic signed [15:0] comp_y;
        logic signed [15:0] comp_z;
        logic signed [15:0] comp_w;
        logic [47:0]        mac_address;
        logic [7:0]         imu_id;
        logic [7:0]         board_id;
        logic [7:0]         mcu_id;
        logic [23:0]        firmware_version;
        logic               last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_MAC,
        CMD_INFO,
        CMD_RAW1,
        CMD_RAW4,
        CMD_ROT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [TRK_W-1:0]   trk;
        logic [127:0]       pkt;
        logic [31:0]        now;
    } t_cmd;

    typedef enum logic {
        F_IDLE,
        F_EXEC
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DECODE,
        B_SQRT,
        B_MULA,
        B_DIVA_GO,
        B_DIVA_WT,
        B_CORDIC,
        B_MULQ,
        B_DIVQ_GO,
        B_DIVQ_WT,
        B_INFO,
        B_QUAT,
        B_ACC,
        B_BAT
    } t_bstate;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd843314857;
            5'd1:    r = 30'd497837829;
            5'd2:    r = 30'd263043837;
            5'd3:    r = 30'd133525159;
            5'd4:    r = 30'd67021687;
            5'd5:    r = 30'd33543516;
            5'd6:    r = 30'd16775851;
            5'd7:    r = 30'd8388437;
            5'd8:    r = 30'd4194283;
            5'd9:    r = 30'd2097149;
            5'd10:   r = 30'd1048576;
            5'd11:   r = 30'd524288;
            5'd12:   r = 30'd262144;
            5'd13:   r = 30'd131072;
            5'd14:   r = 30'd65536;
            5'd15:   r = 30'd32768;
            5'd16:   r = 30'd16384;
            5'd17:   r = 30'd8192;
            5'd18:   r = 30'd4096;
            5'd19:   r = 30'd2048;
            5'd20:   r = 30'd1024;
            5'd21:   r = 30'd512;
            5'd22:   r = 30'd256;
            5'd23:   r = 30'd128;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [33:0] v);
        logic [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'h7fff;
        end else if (v < -34'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[hdl/itpd_queue.sv]
// Short command queue between the decoder front and back.
module itpd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itpd_pkg::t_cmd i_data,
    input  logic           i_pop,
    output itpd_pkg::t_cmd o_data,
    output logic           o_empty,
    output logic           o_full
);
    import itpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hdl/itpd_div.sv]
// Restoring divider, one quotient bit per cycle.
module itpd_div #(
    parameter int NW = 53,
    parameter int DW = 26,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [QW-1:0] o_quo
);
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_low;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   trial;
    logic          fits;

    assign trial  = {r_rem, r_low[QW-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quo  = r_low;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // caller keeps the quotient below 2^QW
            r_rem <= DW'(i_num >> QW);
            r_low <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_den}) : DW'(trial);
            r_low <= {r_low[QW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

endmodule

[hdl/itpd_front.sv]
// Decoder front: length check, id lookup, registration, command issue.
module itpd_front #(
    parameter int MAX_TRACKERS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itpd_pkg::t_in_item i_in,
    output logic               o_push,
    output itpd_pkg::t_cmd     o_cmd,
    input  logic               i_full
);
    import itpd_pkg::*;

    localparam int FW = $clog2(MAX_TRACKERS + 1);

    t_fstate       r_state;
    t_fstate       n_state;
    logic [127:0]  r_pkt;
    logic [31:0]   r_now;
    logic [FW-1:0] r_id_mem [256];
    logic [FW-1:0] r_idx_rd;
    logic [255:0]  r_id_vld;
    logic [FW-1:0] r_next_free;

    logic          accept;
    logic          len_ok;
    logic [7:0]    pkt_type;
    logic [7:0]    pkt_id;
    logic          id_vld;
    logic          can_reg;
    logic          is_reg;
    logic          want_push;
    logic          do_reg;
    t_cmd_kind     kind;

    assign len_ok   = (i_in.report_length != '0) && (i_in.report_length[3:0] == 4'd0);
    assign pkt_type = r_pkt[7:0];
    assign pkt_id   = r_pkt[15:8];
    assign id_vld   = r_id_vld[pkt_id];
    assign can_reg  = !id_vld && (r_next_free < FW'(MAX_TRACKERS));
    assign is_reg   = (pkt_type == TYPE_REG);

    always_comb begin
        kind = CMD_MAC;
        unique case (pkt_type)
            TYPE_INFO: kind = CMD_INFO;
            TYPE_FULL: kind = CMD_RAW1;
            TYPE_QUAT: kind = CMD_RAW4;
            TYPE_ROT:  kind = CMD_ROT;
            default:   kind = CMD_MAC;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid && len_ok) begin
                    n_state = F_EXEC;
                end
            end
            F_EXEC: begin
                if (!(want_push && i_full)) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        accept     = i_in_valid && !o_in_stall;
        want_push  = 1'b0;
        if (r_state == F_EXEC) begin
            if (is_reg) begin
                want_push = id_vld || can_reg;
            end else begin
                want_push = id_vld && (pkt_type == TYPE_INFO || pkt_type == TYPE_FULL ||
                                       pkt_type == TYPE_ROT || pkt_type == TYPE_QUAT);
            end
        end
        o_push    = want_push && !i_full;
        do_reg    = o_push && is_reg && can_reg;
        o_cmd.kind = is_reg ? CMD_MAC : kind;
        o_cmd.trk  = id_vld ? TRK_W'(r_idx_rd) : TRK_W'(r_next_free);
        o_cmd.pkt  = r_pkt;
        o_cmd.now  = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pkt    <= {i_in.packet_high, i_in.packet_low};
            r_now    <= i_in.now_ms;
            r_idx_rd <= r_id_mem[i_in.packet_low[15:8]];
        end
        if (do_reg) begin
            r_id_mem[pkt_id] <= r_next_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_id_vld    <= '0;
            r_next_free <= '0;
        end else begin
            r_state <= n_state;
            if (do_reg) begin
                r_id_vld[pkt_id] <= 1'b1;
                r_next_free      <= r_next_free + 1'b1;
            end
        end
    end

endmodule

[hdl/itpd_back.sv]
// Decoder back: stored tracker data, rotation vector maths, result output.
`include "imu_tracker_packet_decoder_top_defines.svh"
module itpd_back #(
    parameter int MAX_TRACKERS = 15,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itpd_pkg::t_cmd      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic [19:0]         i_batt_int,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itpd_pkg::t_out_item o_out
);
    import itpd_pkg::*;

    localparam int TW      = (MAX_TRACKERS > 1) ? $clog2(MAX_TRACKERS) : 1;
    localparam int CNT_MAX = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int CW      = $clog2(CNT_MAX);

    t_bstate            r_state;
    t_bstate            n_state;
    t_cmd               r_cmd;
    logic [47:0]        r_mac_mem [MAX_TRACKERS];
    logic [31:0]        r_lbt_mem [MAX_TRACKERS];
    logic [MAX_TRACKERS-1:0] r_lbt_vld;
    logic [47:0]        r_mac_rd;
    logic [31:0]        r_lbt_rd;
    logic               r_lbt_vld_rd;
    logic               r_bat_due;

    logic signed [11:0] r_v [3];
    logic [21:0]        r_d;
    logic [31:0]        r_rad;
    logic [31:0]        r_root;
    logic [31:0]        r_bit;
    logic [CW-1:0]      r_cnt;
    logic [52:0]        r_num;
    logic [25:0]        r_den;
    logic               r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [1:0]         r_qi;
    logic               r_neg;
    logic [15:0]        r_q [4];

    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               out_free;
    logic               out_load;
    logic               div_start;
    logic               div_busy;
    logic [31:0]        div_quo;

    logic [TW-1:0]      head_trk;
    logic [TW-1:0]      cur_trk;
    logic [7:0]         bat_raw;
    logic [6:0]         pct;
    logic [9:0]         rq0;
    logic [10:0]        rq1;
    logic [10:0]        rq2;
    logic signed [11:0] v0;
    logic signed [11:0] v1;
    logic signed [11:0] v2;
    logic signed [23:0] dsum;
    logic [32:0]        sq_sum;
    logic [52:0]        prod_a;
    logic signed [45:0] prod_q;
    logic [45:0]        prod_mag;
    logic [31:0]        a_flip;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [33:0] atan_s;
    logic signed [33:0] xw;
    logic [15:0]        q_sat;
    logic [31:0]        since;

    itpd_div #(
        .NW(53),
        .DW(26),
        .QW(32)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_busy (div_busy),
        .o_quo  (div_quo)
    );

    assign head_trk = i_head.trk[TW-1:0];
    assign cur_trk  = r_cmd.trk[TW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // type 2 rotation vector, Q1.10
    assign rq0  = r_cmd.pkt[40 +: 10];
    assign rq1  = r_cmd.pkt[50 +: 11];
    assign rq2  = r_cmd.pkt[61 +: 11];
    assign v0   = $signed({1'b0, rq0, 1'b0}) - 12'sd1024;
    assign v1   = $signed({1'b0, rq1}) - 12'sd1024;
    assign v2   = $signed({1'b0, rq2}) - 12'sd1024;
    assign dsum = v0 * v0 + v1 * v1 + v2 * v2;

    assign sq_sum   = {1'b0, r_root} + {1'b0, r_bit};
    assign prod_a   = HALF_PI_Q30 * r_d;
    assign prod_q   = r_y * r_v[r_qi];
    assign prod_mag = (prod_q < 0) ? 46'(-prod_q) : 46'(prod_q);
    assign a_flip   = PI_Q30 - div_quo;
    assign x_sh     = r_x >>> r_cnt;
    assign y_sh     = r_y >>> r_cnt;
    assign atan_s   = $signed({4'b0, atan_q30(5'(r_cnt))});
    assign xw       = r_flip ? -r_x : r_x;
    assign since    = r_cmd.now - (r_lbt_vld_rd ? r_lbt_rd : 32'd0);

    always_comb begin
        if (r_neg) begin
            q_sat = (div_quo > 32'd32768) ? 16'h8000 : 16'(16'd0 - div_quo[15:0]);
        end else begin
            q_sat = (div_quo > 32'd32767) ? 16'h7fff : div_quo[15:0];
        end
    end

    always_comb begin
        bat_raw = r_cmd.pkt[16 +: 8];
        pct     = (bat_raw == 8'd128) ? 7'd100 : bat_raw[6:0];
        if (pct > 7'd100) begin
            pct = 7'd100;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty && i_head.kind != CMD_MAC) begin
                    n_state = B_DECODE;
                end
            end
            B_DECODE: begin
                unique case (r_cmd.kind)
                    CMD_INFO:           n_state = B_INFO;
                    CMD_RAW1, CMD_RAW4: n_state = B_QUAT;
                    CMD_ROT:            n_state = B_SQRT;
                    default:            n_state = B_IDLE;
                endcase
            end
            B_SQRT: begin
                if (r_cnt == CW'(SQRT_STEPS - 1)) begin
                    n_state = B_MULA;
                end
            end
            B_MULA:    n_state = B_DIVA_GO;
            B_DIVA_GO: n_state = B_DIVA_WT;
            B_DIVA_WT: begin
                if (!div_busy) begin
                    n_state = B_CORDIC;
                end
            end
            B_CORDIC: begin
                if (r_cnt == CW'(CORDIC_STEPS - 1)) begin
                    n_state = B_MULQ;
                end
            end
            B_MULQ:    n_state = B_DIVQ_GO;
            B_DIVQ_GO: n_state = B_DIVQ_WT;
            B_DIVQ_WT: begin
                if (!div_busy) begin
                    n_state = (r_qi == 2'd2) ? B_QUAT : B_MULQ;
                end
            end
            B_INFO: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            B_QUAT: begin
                if (out_free) begin
                    n_state = (r_cmd.kind == CMD_RAW4) ? B_IDLE : B_ACC;
                end
            end
            B_ACC: begin
                if (out_free) begin
                    n_state = (r_cmd.kind == CMD_ROT && r_bat_due) ? B_BAT : B_IDLE;
                end
            end
            B_BAT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_empty;
        div_start = (r_state == B_DIVA_GO) || (r_state == B_DIVQ_GO);
        out_load  = out_free && (r_state == B_INFO || r_state == B_QUAT ||
                                 r_state == B_ACC || r_state == B_BAT);
        n_out = '0;
        n_out.tracker_index = r_cmd.trk[3:0];
        unique case (r_state)
            B_INFO: begin
                n_out.result_kind      = RES_INFO;
                n_out.mac_address      = r_mac_rd;
                n_out.imu_id           = r_cmd.pkt[64 +: 8];
                n_out.board_id         = r_cmd.pkt[40 +: 8];
                n_out.mcu_id           = r_cmd.pkt[48 +: 8];
                n_out.firmware_version = {r_cmd.pkt[96 +: 8], r_cmd.pkt[104 +: 8],
                                          r_cmd.pkt[112 +: 8]};
                n_out.last_of_run      = 1'b1;
            end
            B_QUAT: begin
                n_out.result_kind = RES_ROT;
                n_out.comp_x      = r_q[0];
                n_out.comp_y      = r_q[1];
                n_out.comp_z      = r_q[2];
                n_out.comp_w      = r_q[3];
                n_out.last_of_run = (r_cmd.kind == CMD_RAW4);
            end
            B_ACC: begin
                n_out.result_kind = RES_ACC;
                if (r_cmd.kind == CMD_ROT) begin
                    n_out.comp_x = r_cmd.pkt[72 +: 16];
                    n_out.comp_y = r_cmd.pkt[88 +: 16];
                    n_out.comp_z = r_cmd.pkt[104 +: 16];
                end else begin
                    n_out.comp_x = r_cmd.pkt[80 +: 16];
                    n_out.comp_y = r_cmd.pkt[96 +: 16];
                    n_out.comp_z = r_cmd.pkt[112 +: 16];
                end
                n_out.last_of_run = !(r_cmd.kind == CMD_ROT && r_bat_due);
            end
            B_BAT: begin
                n_out.result_kind = RES_BAT;
                n_out.comp_x      = {8'd0, r_cmd.pkt[24 +: 8]} + 16'd245;
                n_out.comp_y      = {9'd0, pct};
                n_out.last_of_run = 1'b1;
            end
            default: n_out.last_of_run = 1'b0;
        endcase
    end

    // per-tracker stores
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_head.kind == CMD_MAC) begin
                r_mac_mem[head_trk] <= i_head.pkt[16 +: 48];
            end else begin
                r_mac_rd <= r_mac_mem[head_trk];
            end
            r_lbt_rd <= r_lbt_mem[head_trk];
        end
        if (out_load && r_state == B_BAT) begin
            r_lbt_mem[cur_trk] <= r_cmd.now;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        unique case (r_state)
            B_DECODE: begin
                r_q[0]    <= r_cmd.pkt[16 +: 16];
                r_q[1]    <= r_cmd.pkt[32 +: 16];
                r_q[2]    <= r_cmd.pkt[48 +: 16];
                r_q[3]    <= r_cmd.pkt[64 +: 16];
                r_v[0]    <= v0;
                r_v[1]    <= v1;
                r_v[2]    <= v2;
                r_d       <= 22'(dsum);
                r_rad     <= {22'(dsum) + 22'd1, 10'd0};
                r_root    <= '0;
                r_bit     <= 32'h4000_0000;
                r_cnt     <= '0;
                r_bat_due <= (since > {12'd0, i_batt_int});
            end
            B_SQRT: begin
                if ({1'b0, r_rad} >= sq_sum) begin
                    r_rad  <= r_rad - sq_sum[31:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            B_MULA: begin
                r_num <= prod_a;
                r_den <= 26'({r_root[15:0], 5'd0});
            end
            B_DIVA_WT: begin
                if (!div_busy) begin
                    r_flip <= (div_quo > {1'b0, HALF_PI_Q30});
                    r_z    <= (div_quo > {1'b0, HALF_PI_Q30}) ? $signed({2'b0, a_flip})
                                                               : $signed({2'b0, div_quo});
                    r_x    <= $signed({4'b0, GAIN_Q30});
                    r_y    <= '0;
                    r_cnt  <= '0;
                end
            end
            B_CORDIC: begin
                if (r_z >= 0) begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_z <= r_z - atan_s;
                end else begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_z <= r_z + atan_s;
                end
                r_cnt <= r_cnt + 1'b1;
                r_qi  <= '0;
            end
            B_MULQ: begin
                r_num <= 53'(prod_mag);
                r_neg <= (prod_q < 0);
                r_den <= {r_root[15:0], 10'd0};
            end
            B_DIVQ_WT: begin
                if (!div_busy) begin
                    r_q[r_qi] <= q_sat;
                    r_qi      <= r_qi + 1'b1;
                    if (r_qi == 2'd2) begin
                        r_q[3] <= sat16(xw >>> 15);
                    end
                end
            end
            default: r_cnt <= r_cnt;
        endcase
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_out_valid  <= 1'b0;
            r_lbt_vld    <= '0;
            r_lbt_vld_rd <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_lbt_vld_rd <= r_lbt_vld[head_trk];
            end
            if (out_load && r_state == B_BAT) begin
                r_lbt_vld[cur_trk] <= 1'b1;
            end
        end
    end

    `ITPD_ASSERT(a_idle_div_quiet, i_clk, i_rst_n, (r_state == B_IDLE) |-> !div_busy, "divider busy while back end idle")
    `ITPD_ASSERT(a_bat_only_rot, i_clk, i_rst_n, (r_state == B_BAT) |-> (r_cmd.kind == CMD_ROT && r_bat_due), "battery result outside rotation packet")
    `ITPD_ASSERT(a_info_kind, i_clk, i_rst_n, (r_state == B_INFO) |-> (r_cmd.kind == CMD_INFO), "info result for wrong command")

endmodule

[hdl/imu_tracker_packet_decoder_top.sv]
// Top level of the IMU tracker packet decoder.
//
// Input channel i_in_valid / o_in_stall / i_in takes one 16-byte tracker packet
// with its report length and millisecond time stamp per item. Output channel
// o_out_valid / i_out_stall / o_out gives zero to three result items per packet,
// the final one flagged by last_of_run. Configuration channel i_cfg_valid /
// o_cfg_ready / i_cfg_data writes the battery interval; it is always ready.
// The front registers a packet in F_IDLE and issues any command for it from F_EXEC,
// where it waits while the command queue is full; it takes no new packet
// until it is back in F_IDLE. Info and raw quaternion results pass through
// B_DECODE and B_INFO or B_QUAT; the raw acceleration result follows from B_ACC.
// Type 2 packets pass through a 16-step square root, a division, CORDIC_STEPS
// CORDIC steps and three more divisions before the rotation result is loaded;
// the back end takes no new command until it is back in B_IDLE.
// Reset clears the id table, the tracker count, the battery time stamps and
// all handshake state. While i_out_stall is high the result register holds,
// the back end waits and the queue and front fill up until o_in_stall rises.
module imu_tracker_packet_decoder_top #(
    parameter int MAX_TRACKERS = 15,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itpd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itpd_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [19:0]         i_cfg_data
);
    import itpd_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic [19:0] r_batt_int;
    logic        q_push;
    t_cmd        q_in;
    t_cmd        q_head;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt_int <= 20'd10000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_batt_int <= i_cfg_data;
        end
    end

    itpd_front #(
        .MAX_TRACKERS(MAX_TRACKERS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in      (i_in),
        .o_push    (q_push),
        .o_cmd     (q_in),
        .i_full    (q_full)
    );

    itpd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_data (q_head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    itpd_back #(
        .MAX_TRACKERS(MAX_TRACKERS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_batt_int (r_batt_int),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the IMU tracker packet decoder top level.
`timescale 1ns / 1ps

module testbench;
    import itpd_pkg::*;

    localparam int          TRACKERS    = 15;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 300;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DIR_ROWS    = 20;
    localparam int          PHASE_ITEMS = 55;
    localparam logic [7:0]  TYPE_SPARE3 = 8'd3;
    localparam logic [7:0]  TYPE_SPARE  = 8'd200;
    localparam logic [29:0] ATAN_TAB [24] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [19:0] i_cfg_data;

    imu_tracker_packet_decoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // decoder model state
    logic [19:0] bat_interval = 20'd10000;
    logic        id_known [256];
    logic [3:0]  id_trk [256];
    int          trk_count = 0;
    logic [47:0] trk_mac [TRACKERS];
    logic [31:0] trk_bat_time [TRACKERS];

    t_out_item   expected_results [$];
    int          typed_counts [$];
    int          errors = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_off = 1'b0;
    logic [31:0] clock_ms = 32'd50000;
    logic [7:0]  id_pool [20];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [7:0] pkt_byte(t_in_item it, int n);
        return (n < 8) ? it.packet_low[8*n +: 8] : it.packet_high[8*(n-8) +: 8];
    endfunction

    function automatic logic signed [15:0] pkt_s16(t_in_item it, int n);
        return {pkt_byte(it, n + 1), pkt_byte(it, n)};
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // rotation vector (10/11/11 bits) to Q15 quaternion via sqrt and CORDIC
    function automatic void rot_to_quat(logic [31:0] buf_w, ref t_out_item r);
        longint          v [3];
        longint unsigned d;
        longint unsigned s;
        longint unsigned a;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          den;
        logic            flip;
        v[0] = 2 * longint'(buf_w[9:0]) - 1024;
        v[1] = longint'(buf_w[20:10]) - 1024;
        v[2] = longint'(buf_w[31:21]) - 1024;
        d = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        s = root64((d + 1) << 10);
        a = (64'(HALF_PI_Q30) * d) / (s << 5);
        flip = a > 64'(HALF_PI_Q30);
        z = flip ? longint'(PI_Q30) - longint'(a) : longint'(a);
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TAB[i]);
            end
        end
        den = longint'(s << 10);
        r.comp_x = clamp16((y * v[0]) / den);
        r.comp_y = clamp16((y * v[1]) / den);
        r.comp_z = clamp16((y * v[2]) / den);
        r.comp_w = clamp16((flip ? -x : x) >>> 15);
    endfunction

    // works out the results of one packet, queues them, returns their number
    function automatic int decode_packet(t_in_item it);
        t_out_item   r;
        logic [7:0]  kind;
        logic [7:0]  id;
        logic [3:0]  t;
        logic [7:0]  pct;
        logic [7:0]  batt;
        int          n;
        n = 0;
        kind = pkt_byte(it, 0);
        id = pkt_byte(it, 1);
        if (it.report_length == 0 || it.report_length[3:0] != 0) return 0;
        if (kind == TYPE_REG) begin
            if (!id_known[id] && trk_count < TRACKERS) begin
                id_known[id] = 1'b1;
                id_trk[id] = trk_count[3:0];
                trk_count++;
            end
            if (id_known[id]) trk_mac[id_trk[id]] = it.packet_low[63:16];
            return 0;
        end
        if (!id_known[id]) return 0;
        t = id_trk[id];
        r = '0;
        r.tracker_index = t;
        if (kind == TYPE_INFO) begin
            r.result_kind = RES_INFO;
            r.mac_address = trk_mac[t];
            r.imu_id = pkt_byte(it, 8);
            r.board_id = pkt_byte(it, 5);
            r.mcu_id = pkt_byte(it, 6);
            r.firmware_version = {pkt_byte(it, 12), pkt_byte(it, 13), pkt_byte(it, 14)};
            expected_results.push_back(r);
            n++;
        end else if (kind == TYPE_FULL || kind == TYPE_QUAT) begin
            r.result_kind = RES_ROT;
            r.comp_x = pkt_s16(it, 2);
            r.comp_y = pkt_s16(it, 4);
            r.comp_z = pkt_s16(it, 6);
            r.comp_w = pkt_s16(it, 8);
            expected_results.push_back(r);
            n++;
            if (kind == TYPE_FULL) begin
                r.result_kind = RES_ACC;
                r.comp_x = pkt_s16(it, 10);
                r.comp_y = pkt_s16(it, 12);
                r.comp_z = pkt_s16(it, 14);
                r.comp_w = '0;
                expected_results.push_back(r);
                n++;
            end
        end else if (kind == TYPE_ROT) begin
            r.result_kind = RES_ROT;
            rot_to_quat({pkt_byte(it, 8), pkt_byte(it, 7), pkt_byte(it, 6),
                         pkt_byte(it, 5)}, r);
            expected_results.push_back(r);
            r.result_kind = RES_ACC;
            r.comp_x = pkt_s16(it, 9);
            r.comp_y = pkt_s16(it, 11);
            r.comp_z = pkt_s16(it, 13);
            r.comp_w = '0;
            expected_results.push_back(r);
            n += 2;
            if (it.now_ms - trk_bat_time[t] > 32'(bat_interval)) begin
                batt = pkt_byte(it, 2);
                pct = (batt == 8'd128) ? 8'd100 : {1'b0, batt[6:0]};
                if (pct > 100) pct = 8'd100;
                trk_bat_time[t] = it.now_ms;
                r.result_kind = RES_BAT;
                r.comp_x = 16'(pkt_byte(it, 3)) + 16'sd245;
                r.comp_y = 16'(pct);
                r.comp_z = '0;
                expected_results.push_back(r);
                n++;
            end
        end
        if (n > 0) expected_results[$].last_of_run = 1'b1;
        return n;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        int        n;
        int        tn;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected result kind", o_out.result_kind, 0);
            end else begin
                e = expected_results.pop_front();
                if (o_out.result_kind != e.result_kind)
                    report("result_kind", o_out.result_kind, e.result_kind);
                if (o_out.tracker_index != e.tracker_index)
                    report("tracker_index", o_out.tracker_index, e.tracker_index);
                if (o_out.comp_x != e.comp_x) report("comp_x", o_out.comp_x, e.comp_x);
                if (o_out.comp_y != e.comp_y) report("comp_y", o_out.comp_y, e.comp_y);
                if (o_out.comp_z != e.comp_z) report("comp_z", o_out.comp_z, e.comp_z);
                if (o_out.comp_w != e.comp_w) report("comp_w", o_out.comp_w, e.comp_w);
                if (o_out.mac_address != e.mac_address)
                    report("mac_address", o_out.mac_address, e.mac_address);
                if (o_out.imu_id != e.imu_id) report("imu_id", o_out.imu_id, e.imu_id);
                if (o_out.board_id != e.board_id)
                    report("board_id", o_out.board_id, e.board_id);
                if (o_out.mcu_id != e.mcu_id) report("mcu_id", o_out.mcu_id, e.mcu_id);
                if (o_out.firmware_version != e.firmware_version)
                    report("firmware_version", o_out.firmware_version, e.firmware_version);
                if (o_out.last_of_run != e.last_of_run)
                    report("last_of_run", o_out.last_of_run, e.last_of_run);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            n = decode_packet(i_in);
            tn = typed_counts.pop_front();
            if (tn >= 0 && tn != n) report("results per item", n, tn);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(t_in_item it, int n_typed);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        typed_counts.push_back(n_typed);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained(int extra);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_interval(logic [19:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bat_interval = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(logic [63:0] lo, logic [63:0] hi,
                                           logic [6:0] len, logic [31:0] now);
        t_in_item it;
        it.packet_low = lo;
        it.packet_high = hi;
        it.report_length = len;
        it.now_ms = now;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       roll;
        logic [7:0] kind;
        it.packet_low = {$urandom, $urandom};
        it.packet_high = {$urandom, $urandom};
        it.report_length = 7'(16 * $urandom_range(1, 7));
        if ($urandom_range(19) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 6000);
        it.now_ms = clock_ms;
        roll = $urandom_range(99);
        if (roll < 10) kind = TYPE_REG;
        else if (roll < 20) kind = TYPE_INFO;
        else if (roll < 38) kind = TYPE_FULL;
        else if (roll < 48) kind = TYPE_QUAT;
        else if (roll < 90) kind = TYPE_ROT;
        else kind = 8'($urandom);
        it.packet_low[7:0] = kind;
        if (roll < 95) it.packet_low[15:8] = id_pool[$urandom_range(19)];
        if ($urandom_range(24) == 0) it.report_length = 7'($urandom);
        return it;
    endfunction

    initial begin
        t_in_item    dir_item [DIR_ROWS];
        int          dir_n [DIR_ROWS];
        int          phase_idle [4] = '{0, 85, 0, 19};
        int          phase_stall [4] = '{0, 0, 85, 19};
        logic [19:0] phase_interval [4];

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        for (int i = 0; i < 256; i++) begin
            id_known[i] = 1'b0;
            id_trk[i] = '0;
        end
        for (int i = 0; i < TRACKERS; i++) begin
            trk_mac[i] = '0;
            trk_bat_time[i] = '0;
        end
        for (int i = 0; i < 20; i++) id_pool[i] = 8'($urandom);
        id_pool[0] = 8'h11;
        id_pool[1] = 8'h00;
        phase_interval = '{20'd0, 20'hfffff, 20'd1000000, 20'($urandom_range(1, 20000))};

        dir_item[0]  = make_item(64'h6655_4433_2211_11ff, '0, 7'd16, 32'd100);
        dir_n[0]     = 0;
        dir_item[1]  = make_item(64'h00bb_aa00_0000_1100, 64'h0003_0201_0000_0042,
                                 7'd16, 32'd100);
        dir_n[1]     = 1;
        dir_item[2]  = make_item(64'h8000_7fff_8000_1101, 64'hffff_7fff_8000_7fff,
                                 7'd32, 32'd100);
        dir_n[2]     = 2;
        dir_item[3]  = make_item(64'h0001_ffff_0000_1104, '0, 7'd48, 32'd100);
        dir_n[3]     = 1;
        dir_item[4]  = make_item(64'h0000_0000_ff80_1102, '0, 7'd16, 32'd20000);
        dir_n[4]     = 3;
        dir_item[5]  = make_item(64'hffff_ff00_0000_1102, 64'h7fff_8000_7fff_00ff,
                                 7'd16, 32'd20001);
        dir_n[5]     = 2;
        dir_item[6]  = make_item(64'h1234_5600_007f_1102, 64'h0000_0000_0000_0091,
                                 7'd16, 32'd40000);
        dir_n[6]     = 3;
        dir_item[7]  = make_item(64'h0000_0000_0000_1101, '0, 7'd0, 32'd0);
        dir_n[7]     = 0;
        dir_item[8]  = make_item(64'h0000_0000_0000_1101, '0, 7'd17, 32'd0);
        dir_n[8]     = 0;
        dir_item[9]  = make_item(64'h0000_0000_0000_1101, '0, 7'd127, 32'd0);
        dir_n[9]     = 0;
        dir_item[10] = make_item(64'h5555_aaaa_5555_1104, 64'haaaa, 7'd112, 32'd0);
        dir_n[10]    = 1;
        dir_item[11] = make_item(64'hffff_ffff_ffff_1100, 64'hffff_ffff_ffff_ffff,
                                 7'd64, 32'd0);
        dir_n[11]    = 1;
        dir_item[12] = make_item(64'h0000_0000_0000_2201, '0, 7'd16, 32'd0);
        dir_n[12]    = 0;
        dir_item[13] = make_item({48'h0, 8'h11, TYPE_SPARE3}, '0, 7'd16, 32'd0);
        dir_n[13]    = 0;
        dir_item[14] = make_item({48'h0, 8'h11, TYPE_SPARE}, '0, 7'd16, 32'd0);
        dir_n[14]    = 0;
        dir_item[15] = make_item(64'hfedc_ba98_7654_11ff, '0, 7'd16, 32'd0);
        dir_n[15]    = 0;
        dir_item[16] = make_item(64'h0000_0000_0000_1100, '0, 7'd16, 32'd0);
        dir_n[16]    = 1;
        dir_item[17] = make_item(64'hffff_ffff_ffff_00ff, '0, 7'd16, 32'd0);
        dir_n[17]    = 0;
        dir_item[18] = make_item(64'h4020_0100_0000_0002, 64'h8000_7fff_0040,
                                 7'd16, 32'd0);
        dir_n[18]    = 2;
        dir_item[19] = make_item(64'h0000_0000_00ff_0002, '0, 7'd16, 32'hffff_ffff);
        dir_n[19]    = 3;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) send_item(dir_item[i], dir_n[i]);

        for (int p = 0; p < 4; p++) begin
            wait_drained(SETTLE);
            write_interval(phase_interval[p]);
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 8) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (HOLD_CYCLES) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (p == 2 && k == 30) wait_drained(0);
                send_item(random_item(), -1);
            end
        end

        wait_drained(SETTLE);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
